// File: rtl/tdpc_pkg.sv
// shared types and constants for the trial division prime counter
`timescale 1ns / 1ps

package tdpc_pkg;

   // fixed widths of the channel payload fields
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 32;

   // first trial divisor, also the smallest prime
   localparam int FIRST_DIVISOR = 2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_DONE
   } state_type;

endpackage

// File: rtl/tdpc_channels.sv
// valid/ready channel interfaces for request and response
`timescale 1ns / 1ps

interface tdpc_req_if
   import tdpc_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;
   logic                   restart;

   modport source (output valid, output value, output restart, input ready);
   modport sink   (input valid, input value, input restart, output ready);
endinterface

interface tdpc_rsp_if
   import tdpc_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   prime_flag;
   logic [COUNT_WIDTH-1:0] prime_count;

   modport source (output valid, output prime_flag, output prime_count, input ready);
   modport sink   (input valid, input prime_flag, input prime_count, output ready);
endinterface

// File: rtl/tdpc_divider.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tdpc_divider #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int STEP_BITS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [WIDTH-1:0]     rem_ff, rem_in;
   logic [WIDTH-1:0]     quo_ff, quo_in;
   logic [WIDTH:0]       shifted;
   logic [WIDTH:0]       diff;

   // shift in the next dividend bit and trial subtract
   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(WIDTH - 1);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (diff[WIDTH]) begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end else begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_BITS'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/trial_division_prime_counter_core.sv
// top level: trial division sequencer, prime counter and response register
`timescale 1ns / 1ps

// Tests one unsigned value per request for primality by trial division and
// returns the prime flag together with a saturating running count of primes;
// a set restart flag clears the count before the value is counted. Divisors
// d = 2, 3, ... are tried while d <= value / d, stopping at the first that
// divides evenly; values 0 and 1 are not prime. All divisions run on one
// shared restoring divider that produces one quotient bit per cycle. A
// prime v needs floor(sqrt(v)) trials. One request is in work at a time:
// req ready is low from acceptance until the response transfer.

module trial_division_prime_counter_core
   import tdpc_pkg::*;
#(
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   tdpc_req_if.sink        req_chan,
   tdpc_rsp_if.source      rsp_chan
);

   localparam int DIV_BITS = VALUE_BITS / 2 + 1;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] held_value_ff, held_value_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [DIV_BITS-1:0]   divisor_ff, divisor_in;
   logic                  prime_ff, prime_in;
   logic                  div_start;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [VALUE_BITS-1:0] div_remainder;
   logic [VALUE_BITS-1:0] value_ext;
   logic [VALUE_BITS-1:0] divisor_ext;

   assign value_ext   = VALUE_BITS'(req_chan.value);
   assign divisor_ext = VALUE_BITS'(divisor_ff);

   // shared divider gives value / d and value % d for each trial
   tdpc_divider #(
      .WIDTH (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (held_value_ff),
      .divisor   (divisor_ext),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // sequencer: next state, trial divisor and count update
   always_comb begin
      state_in      = state_ff;
      held_value_in = held_value_ff;
      count_in      = count_ff;
      divisor_in    = divisor_ff;
      prime_in      = prime_ff;
      div_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               held_value_in = value_ext;
               divisor_in    = DIV_BITS'(FIRST_DIVISOR);
               if (req_chan.restart) begin
                  count_in = '0;
               end
               if (value_ext < VALUE_BITS'(FIRST_DIVISOR)) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               if (divisor_ext > div_quotient) begin
                  // d*d exceeds the value: no divisor found
                  prime_in = 1'b1;
                  if (count_ff != '1) begin
                     count_in = count_ff + COUNT_BITS'(1);
                  end
                  state_in = ST_DONE;
               end else if (div_remainder == '0) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  divisor_in = divisor_ff + DIV_BITS'(1);
                  state_in   = ST_START;
               end
            end
         end
         ST_DONE: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         held_value_ff <= '0;
         divisor_ff    <= DIV_BITS'(FIRST_DIVISOR);
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         held_value_ff <= held_value_in;
         divisor_ff    <= divisor_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prime_ff <= prime_in;
   end

   // handshake and response payload
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_DONE);
   assign rsp_chan.prime_flag  = prime_ff;
   assign rsp_chan.prime_count = COUNT_WIDTH'(count_ff);

endmodule

// File: rtl/tdpc_checker.sv
// port-level checker for the prime counter core and its bind
`timescale 1ns / 1ps

module tdpc_checker
   import tdpc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_prime_flag,
   input logic [COUNT_WIDTH-1:0] rsp_prime_count
);

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prime_flag)
         && $stable(rsp_prime_count))
      else $error("response changed while stalled");

   // the core is busy right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   // only one item in work: no request taken while a response waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready high with a response pending");

   // the core is ready again once the response transfer completes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("core not idle after response transfer");

endmodule

bind trial_division_prime_counter_core tdpc_checker u_tdpc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_prime_flag  (rsp_chan.prime_flag),
   .rsp_prime_count (rsp_chan.prime_count)
);
